// File: rtl/core/mer_pkg.sv
package mer_pkg;

    localparam int COORD_W_DEF  = 10;
    localparam int RADIUS_W_DEF = 9;
    localparam int PIX_W        = 12;
    localparam int COLOR_W      = 8;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [3:0] {
        ES_IDLE,
        ES_SQA,
        ES_SQB,
        ES_INIT,
        ES_INIT2,
        ES_D1,
        ES_D2,
        ES_D3,
        ES_D4,
        ES_D5,
        ES_SW
    } t_eng_state;

    typedef struct packed {
        logic start;
        logic step;
    } t_eng_ctl;

    typedef struct packed {
        logic busy;
        logic active;
        logic fin;
    } t_eng_stat;

endpackage

// File: rtl/core/mer_mul.sv
module mer_mul #(
    parameter int A_WIDTH = 19,
    parameter int B_WIDTH = 13
) (
    input  logic                                i_clk,
    input  logic signed [A_WIDTH-1:0]           i_op_a,
    input  logic signed [B_WIDTH-1:0]           i_op_b,
    output logic signed [A_WIDTH+B_WIDTH-1:0]   o_prod
);

    logic signed [A_WIDTH+B_WIDTH-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/core/mer_engine.sv
module mer_engine #(
    parameter int RADIUS_WIDTH = mer_pkg::RADIUS_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mer_pkg::t_eng_ctl             i_ctl,
    input  logic [RADIUS_WIDTH-1:0]       i_radius_x,
    input  logic [RADIUS_WIDTH-1:0]       i_radius_y,
    output mer_pkg::t_eng_stat            o_stat,
    output logic signed [RADIUS_WIDTH+1:0] o_walk_x,
    output logic signed [RADIUS_WIDTH+1:0] o_walk_y
);
    import mer_pkg::*;

    localparam int RW  = RADIUS_WIDTH;
    localparam int WW  = RW + 2;
    localparam int SQW = 2 * RW;
    localparam int AW  = SQW + 1;
    localparam int BW  = RW + 4;
    localparam int MW  = AW + BW;
    localparam int DW  = 3 * RW + 8;

    localparam logic signed [BW-1:0] ONE_B = BW'(1);
    localparam logic signed [BW-1:0] SIX_B = BW'(6);
    localparam logic signed [WW-1:0] ONE_W = WW'(1);

    t_eng_state r_state, n_state;

    logic [RW-1:0]          r_semi_a;
    logic [SQW-1:0]         r_a2, r_b2;
    logic signed [WW-1:0]   r_wx, r_wy;
    logic signed [DW-1:0]   r_d;
    logic signed [MW-1:0]   r_cmp;
    logic                   r_take;
    logic                   r_region;
    logic                   r_active;
    logic                   r_fin;

    logic [SQW-1:0]         w_opa_u;
    logic signed [BW-1:0]   w_opb;
    logic signed [MW-1:0]   w_prod;
    logic signed [DW-1:0]   w_prod_ext;

    // region 0 walks x up and y down; region 1 swaps the roles
    logic [SQW-1:0]         w_p, w_q;
    logic signed [WW-1:0]   w_pw, w_qv;
    logic signed [BW-1:0]   w_pw_ext, w_qv_ext, w_semi_ext, w_b_ext;
    logic                   w_zero;
    logic                   w_fail;

    assign w_p  = r_region ? r_b2 : r_a2;
    assign w_q  = r_region ? r_a2 : r_b2;
    assign w_pw = r_region ? r_wx : r_wy;
    assign w_qv = r_region ? r_wy : r_wx;

    assign w_pw_ext   = {{(BW-WW){w_pw[WW-1]}}, w_pw};
    assign w_qv_ext   = {{(BW-WW){w_qv[WW-1]}}, w_qv};
    assign w_semi_ext = signed'({{(BW-RW){1'b0}}, r_semi_a});
    assign w_b_ext    = signed'({{(BW-RW){1'b0}}, r_wy[RW-1:0]});
    assign w_prod_ext = {{(DW-MW){w_prod[MW-1]}}, w_prod};
    assign w_zero     = (r_a2 == '0) && (r_b2 == '0);
    assign w_fail     = r_cmp > w_prod;

    mer_mul #(
        .A_WIDTH (AW),
        .B_WIDTH (BW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_op_a (signed'({1'b0, w_opa_u})),
        .i_op_b (w_opb),
        .o_prod (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_opa_u = '0;
        w_opb   = '0;
        case (r_state)
            ES_IDLE: begin
                if (i_ctl.start) begin
                    n_state = ES_SQA;
                end else if (i_ctl.step) begin
                    n_state = ES_D1;
                end
            end
            ES_SQA: begin
                w_opa_u = SQW'(r_semi_a);
                w_opb   = w_semi_ext;
                n_state = ES_SQB;
            end
            ES_SQB: begin
                w_opa_u = SQW'(r_wy[RW-1:0]);
                w_opb   = w_b_ext;
                n_state = ES_INIT;
            end
            ES_INIT: begin
                w_opa_u = r_a2;
                w_opb   = ONE_B - (w_b_ext <<< 1);
                n_state = ES_INIT2;
            end
            ES_INIT2: begin
                n_state = ES_D1;
            end
            ES_D1: begin
                w_opa_u = w_p;
                w_opb   = ONE_B - w_pw_ext;
                n_state = w_zero ? ES_IDLE : ES_D2;
            end
            ES_D2: begin
                w_opa_u = w_q;
                w_opb   = (w_qv_ext <<< 2) + SIX_B;
                n_state = ES_D3;
            end
            ES_D3: begin
                // walk register still holds the old value here
                w_opa_u = w_q;
                w_opb   = w_qv_ext + ONE_B;
                n_state = ES_D4;
            end
            ES_D4: begin
                w_opa_u = w_p;
                w_opb   = w_pw_ext;
                n_state = ES_D5;
            end
            ES_D5: begin
                w_opa_u = r_b2;
                w_opb   = ONE_B - (w_semi_ext <<< 1);
                n_state = (!r_region && w_fail) ? ES_SW : ES_IDLE;
            end
            ES_SW: begin
                n_state = ES_IDLE;
            end
            default: begin
                n_state = ES_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= 1'b0;
            r_active <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            if (i_ctl.start || i_ctl.step) begin
                r_fin <= 1'b0;
            end
            if (i_ctl.start) begin
                r_region <= 1'b0;
                r_active <= 1'b1;
            end
            if (r_state == ES_D1 && w_zero) begin
                r_fin    <= 1'b1;
                r_active <= 1'b0;
            end
            if (r_state == ES_D5) begin
                if (r_region && w_fail) begin
                    r_fin    <= 1'b1;
                    r_active <= 1'b0;
                end else if (!r_region && w_fail) begin
                    r_region <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_semi_a <= i_radius_x;
            r_wx     <= '0;
            r_wy     <= signed'({{(WW-RW){1'b0}}, i_radius_y});
        end
        case (r_state)
            ES_SQB: begin
                r_a2 <= w_prod[SQW-1:0];
            end
            ES_INIT: begin
                r_b2 <= w_prod[SQW-1:0];
            end
            ES_INIT2: begin
                r_d <= signed'({{(DW-SQW){1'b0}}, r_b2} << 1) + w_prod_ext;
            end
            ES_D1: begin
                r_take <= !r_d[DW-1];
            end
            ES_D2: begin
                if (r_take) begin
                    r_d <= r_d + (w_prod_ext <<< 2);
                    if (r_region) begin
                        r_wx <= r_wx - ONE_W;
                    end else begin
                        r_wy <= r_wy - ONE_W;
                    end
                end
            end
            ES_D3: begin
                r_d <= r_d + w_prod_ext;
                if (r_region) begin
                    r_wy <= r_wy + ONE_W;
                end else begin
                    r_wx <= r_wx + ONE_W;
                end
            end
            ES_D4: begin
                r_cmp <= w_prod;
            end
            ES_D5: begin
                if (!r_region && w_fail) begin
                    r_wx <= signed'({{(WW-RW){1'b0}}, r_semi_a});
                    r_wy <= '0;
                end
            end
            ES_SW: begin
                r_d <= signed'({{(DW-SQW){1'b0}}, r_a2} << 1) + w_prod_ext;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.busy   = (r_state != ES_IDLE);
    assign o_stat.active = r_active;
    assign o_stat.fin    = r_fin;
    assign o_walk_x      = r_wx;
    assign o_walk_y      = r_wy;

endmodule

// File: rtl/core/mer_emit.sv
module mer_emit #(
    parameter int COORD_WIDTH = mer_pkg::COORD_W_DEF,
    parameter int WALK_WIDTH  = mer_pkg::RADIUS_W_DEF + 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_emit,
    input  logic                               i_start,
    input  logic [COORD_WIDTH-1:0]             i_center_x,
    input  logic [COORD_WIDTH-1:0]             i_center_y,
    input  logic [mer_pkg::COLOR_W-1:0]        i_ink,
    input  logic signed [WALK_WIDTH-1:0]       i_walk_x,
    input  logic signed [WALK_WIDTH-1:0]       i_walk_y,
    input  mer_pkg::t_eng_stat                 i_eng_stat,
    output logic                               o_grp_valid,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [mer_pkg::PIX_W-1:0]   o_pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]   o_pixel_y,
    output logic [mer_pkg::COLOR_W-1:0]        o_pixel_color,
    output logic                               o_group_last,
    output logic                               o_figure_done
);
    import mer_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int WW = WALK_WIDTH;
    localparam int SA = (CW + 1 > WW) ? CW + 1 : WW;
    localparam int SW = ((SA > PIX_W) ? SA : PIX_W) + 1;
    localparam logic [1:0] LAST_BEAT = 2'd3;

    logic [CW-1:0]        r_origin_x, r_origin_y;
    logic [COLOR_W-1:0]   r_ink;
    logic [PIX_W-1:0]     r_px_p, r_px_n, r_py_p, r_py_n;
    logic [1:0]           r_beat;
    logic                 r_valid;

    logic [CW-1:0]        w_ox, w_oy;
    logic signed [SW-1:0] w_ox_ext, w_oy_ext, w_wx_ext, w_wy_ext;
    logic signed [SW-1:0] w_xp, w_xn, w_yp, w_yn;
    logic                 w_last;

    always_comb begin
        w_ox     = i_start ? i_center_x : r_origin_x;
        w_oy     = i_start ? i_center_y : r_origin_y;
        w_ox_ext = signed'({{(SW-CW){1'b0}}, w_ox});
        w_oy_ext = signed'({{(SW-CW){1'b0}}, w_oy});
        w_wx_ext = {{(SW-WW){i_walk_x[WW-1]}}, i_walk_x};
        w_wy_ext = {{(SW-WW){i_walk_y[WW-1]}}, i_walk_y};
        w_xp     = w_ox_ext + w_wx_ext;
        w_xn     = w_ox_ext - w_wx_ext;
        w_yp     = w_oy_ext + w_wy_ext;
        w_yn     = w_oy_ext - w_wy_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_origin_x <= i_center_x;
            r_origin_y <= i_center_y;
            r_ink      <= i_ink;
        end
        if (i_emit) begin
            r_px_p <= w_xp[PIX_W-1:0];
            r_px_n <= w_xn[PIX_W-1:0];
            r_py_p <= w_yp[PIX_W-1:0];
            r_py_n <= w_yn[PIX_W-1:0];
        end
    end

    assign w_last = (r_beat == LAST_BEAT);
    // last beat of a group holds until the step result (done flag) is known
    assign o_out_valid = r_valid && !(w_last && i_eng_stat.busy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else if (i_emit) begin
            r_valid <= 1'b1;
            r_beat  <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_beat <= r_beat + 2'd1;
            if (w_last) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_grp_valid   = r_valid;
    assign o_pixel_x     = signed'(r_beat[0] ? r_px_n : r_px_p);
    assign o_pixel_y     = signed'(r_beat[1] ? r_py_n : r_py_p);
    assign o_pixel_color = r_ink;
    assign o_group_last  = w_last;
    assign o_figure_done = w_last && i_eng_stat.fin;

endmodule

// File: rtl/core/midpoint_ellipse_rasterizer_core.sv
// Axis-aligned midpoint ellipse rasterizer. A start beat (cmd 0) latches the
// center, both semi-axes and the ink, and a step beat (cmd 1) advances the
// walk; each accepted start or step of a running figure yields one group of
// four pixel beats in the order (+x,+y) (-x,+y) (+x,-y) (-x,-y), with
// group_last on the fourth and figure_done on the fourth beat of the final
// group. Axis pixels repeat, and coordinates wrap to 12 bits. The decision
// update runs through a single shared multiplier under a small sequencer,
// while the four pixel beats drain from an output buffer in parallel; the
// fourth beat waits for the step to finish. A new input beat is accepted only
// once the sequencer is idle and the last group has drained; a step sent while
// no figure is running is accepted and yields nothing.
module midpoint_ellipse_rasterizer_core #(
    parameter int COORD_WIDTH  = mer_pkg::COORD_W_DEF,
    parameter int RADIUS_WIDTH = mer_pkg::RADIUS_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [COORD_WIDTH-1:0]            i_center_x,
    input  logic [COORD_WIDTH-1:0]            i_center_y,
    input  logic [RADIUS_WIDTH-1:0]           i_radius_x,
    input  logic [RADIUS_WIDTH-1:0]           i_radius_y,
    input  logic [mer_pkg::COLOR_W-1:0]       i_ink,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mer_pkg::PIX_W-1:0]  o_pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]  o_pixel_y,
    output logic [mer_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                              o_group_last,
    output logic                              o_figure_done
);
    import mer_pkg::*;

    localparam int WW = RADIUS_WIDTH + 2;

    t_eng_ctl             w_ctl;
    t_eng_stat            w_stat;
    logic                 w_accept;
    logic                 w_emit;
    logic                 w_grp_valid;
    logic signed [WW-1:0] w_eng_wx, w_eng_wy;
    logic signed [WW-1:0] w_walk_x, w_walk_y;

    assign o_in_ready = !w_stat.busy && !w_grp_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ctl.start = w_accept && (i_cmd == CMD_START);
    assign w_ctl.step  = w_accept && (i_cmd == CMD_STEP) && w_stat.active;
    assign w_emit      = w_ctl.start || w_ctl.step;

    // first group of a new figure sits at (0, b)
    assign w_walk_x = w_ctl.start ? '0 : w_eng_wx;
    assign w_walk_y = w_ctl.start ? signed'({2'b00, i_radius_y}) : w_eng_wy;

    mer_engine #(
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_radius_x (i_radius_x),
        .i_radius_y (i_radius_y),
        .o_stat     (w_stat),
        .o_walk_x   (w_eng_wx),
        .o_walk_y   (w_eng_wy)
    );

    mer_emit #(
        .COORD_WIDTH (COORD_WIDTH),
        .WALK_WIDTH  (WW)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_emit        (w_emit),
        .i_start       (w_ctl.start),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_ink         (i_ink),
        .i_walk_x      (w_walk_x),
        .i_walk_y      (w_walk_y),
        .i_eng_stat    (w_stat),
        .o_grp_valid   (w_grp_valid),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_group_last  (o_group_last),
        .o_figure_done (o_figure_done)
    );

endmodule

// File: rtl/core/mer_checker.sv
module mer_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic                              o_group_last,
    input  logic                              o_figure_done
);
    import mer_pkg::*;

    // a pending result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_figure_done |-> o_group_last)
        else $error("figure_done outside the last beat of a group");

    // input side only opens once the previous group has fully drained
    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while result beats are pending");

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_START) |=> o_out_valid)
        else $error("start beat did not produce a pixel beat");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_mer_checker (.*);
